### design/rnta_pkg.sv
// rnta_pkg: shared types, constants and the digit-to-ASCII function for the
// radix number to ASCII converter. Used by rnta_ctrl, rnta_dpath and the top level.
// No dependencies.
package rnta_pkg;

    // Fixed port widths
    localparam int WHOLE_PORT_WIDTH    = 31;
    localparam int FRACTION_PORT_WIDTH = 32;
    localparam int CHAR_WIDTH          = 8;
    localparam int RADIX_WIDTH         = 5;
    localparam int FDIG_WIDTH          = 5;
    localparam int DIGIT_WIDTH         = 4;
    localparam int CFG_INDEX_WIDTH     = 1;
    localparam int CFG_DATA_WIDTH      = 5;

    // Restoring-division bit steps handled per clock
    localparam int DIV_STEPS = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIX           = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRACTION_DIGITS = 1'd1;

    // Register reset values and limits
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 5'd16;
    localparam logic [FDIG_WIDTH-1:0]  FDIG_RESET  = 5'd6;
    localparam logic [FDIG_WIDTH-1:0]  FDIG_MAX    = 5'd30;

    // Characters
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX_DEC = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_POP,
        ST_POINT,
        ST_FRAC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_finish;
        logic emit_sign;
        logic emit_pop;
        logic emit_point;
        logic emit_frac;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic quo_zero;
        logic pop_last;
        logic point_last;
        logic frac_last;
    } status_t;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] ext;
        ext = {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, d};
        if (d > DIGIT_MAX_DEC)
        begin
            return ext - 8'd10 + CHAR_A;
        end
        return ext + CHAR_ZERO;
    endfunction

endpackage

### design/rnta_ctrl.sv
// rnta_ctrl: sequencing state machine for the converter.
// Depends on rnta_pkg (state_t, cmd_t, status_t, DIV_STEPS).
module rnta_ctrl #(
    parameter int WHOLE_WIDTH = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rnta_pkg::status_t stat,
    output rnta_pkg::cmd_t    cmd
);

    localparam int DIV_CYCLES = (WHOLE_WIDTH + rnta_pkg::DIV_STEPS - 1) / rnta_pkg::DIV_STEPS;
    localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    rnta_pkg::state_t state_reg;
    rnta_pkg::state_t state_next;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0] div_cnt_next;
    logic             div_cnt_end;

    assign div_cnt_end = (div_cnt_reg == CNT_LAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rnta_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rnta_pkg::ST_DIV;
                end
            end
            rnta_pkg::ST_DIV:
            begin
                if (div_cnt_end && stat.quo_zero)
                begin
                    state_next = rnta_pkg::ST_SIGN;
                end
            end
            rnta_pkg::ST_SIGN:
            begin
                if (stat.out_free)
                begin
                    state_next = rnta_pkg::ST_POP;
                end
            end
            rnta_pkg::ST_POP:
            begin
                if (stat.out_free && stat.pop_last)
                begin
                    state_next = rnta_pkg::ST_POINT;
                end
            end
            rnta_pkg::ST_POINT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.point_last ? rnta_pkg::ST_IDLE : rnta_pkg::ST_FRAC;
                end
            end
            rnta_pkg::ST_FRAC:
            begin
                if (stat.out_free && stat.frac_last)
                begin
                    state_next = rnta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rnta_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            rnta_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load     = in_valid;
                div_cnt_next = '0;
            end
            rnta_pkg::ST_DIV:
            begin
                cmd.div_step   = 1'b1;
                cmd.div_finish = div_cnt_end;
                div_cnt_next   = div_cnt_end ? '0 : div_cnt_reg + 1'b1;
            end
            rnta_pkg::ST_SIGN:
            begin
                cmd.emit_sign = stat.out_free;
            end
            rnta_pkg::ST_POP:
            begin
                cmd.emit_pop = stat.out_free;
            end
            rnta_pkg::ST_POINT:
            begin
                cmd.emit_point = stat.out_free;
            end
            rnta_pkg::ST_FRAC:
            begin
                cmd.emit_frac = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rnta_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

### design/rnta_dpath.sv
// rnta_dpath: configuration registers, radix divider, digit stack, fraction
// multiplier and output register. Depends on rnta_pkg (cmd_t, status_t, constants).
module rnta_dpath #(
    parameter int WHOLE_WIDTH    = 31,
    parameter int FRACTION_WIDTH = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  rnta_pkg::cmd_t                               cmd,
    output rnta_pkg::status_t                            stat,
    input  logic                                         is_negative,
    input  logic [rnta_pkg::WHOLE_PORT_WIDTH-1:0]        whole_part,
    input  logic [rnta_pkg::FRACTION_PORT_WIDTH-1:0]     fraction_part,
    input  logic                                         cfg_valid,
    input  logic [rnta_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
    input  logic [rnta_pkg::CFG_DATA_WIDTH-1:0]          cfg_data,
    input  logic                                         out_stall,
    output logic                                         out_valid,
    output logic [rnta_pkg::CHAR_WIDTH-1:0]              character,
    output logic                                         last
);

    localparam int DIV_BITS = ((WHOLE_WIDTH + rnta_pkg::DIV_STEPS - 1) / rnta_pkg::DIV_STEPS)
                              * rnta_pkg::DIV_STEPS;
    localparam int DEPTH_W  = $clog2(WHOLE_WIDTH + 1);
    localparam int PROD_W   = FRACTION_WIDTH + rnta_pkg::RADIX_WIDTH;
    localparam int DW       = rnta_pkg::DIGIT_WIDTH;
    localparam int RW       = rnta_pkg::RADIX_WIDTH;

    // Configuration
    logic [RW-1:0]                   radix_reg;
    logic [RW-1:0]                   radix_next;
    logic [rnta_pkg::FDIG_WIDTH-1:0] fdig_reg;
    logic [rnta_pkg::FDIG_WIDTH-1:0] fdig_next;
    logic [RW-1:0]                   radix_sat;
    logic [rnta_pkg::FDIG_WIDTH-1:0] fdig_sat;

    // Working registers
    logic [DIV_BITS-1:0]             div_reg;
    logic [DIV_BITS-1:0]             div_next;
    logic [DW-1:0]                   rem_reg;
    logic [DW-1:0]                   rem_next;
    logic [FRACTION_WIDTH-1:0]       frac_reg;
    logic [FRACTION_WIDTH-1:0]       frac_next;
    logic [rnta_pkg::FDIG_WIDTH-1:0] fd_left_reg;
    logic [rnta_pkg::FDIG_WIDTH-1:0] fd_left_next;
    logic                            sign_reg;
    logic                            sign_next;
    logic [DW-1:0]                   stack_reg [WHOLE_WIDTH];
    logic [DW-1:0]                   stack_next [WHOLE_WIDTH];
    logic [DEPTH_W-1:0]              depth_reg;
    logic [DEPTH_W-1:0]              depth_next;

    // Output register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [rnta_pkg::CHAR_WIDTH-1:0] char_reg;
    logic [rnta_pkg::CHAR_WIDTH-1:0] char_next;
    logic                            last_reg;
    logic                            last_next;

    // Arithmetic
    logic [DIV_BITS-1:0]             div_d;
    logic [RW-1:0]                   div_r;
    logic [PROD_W-1:0]               prod;
    logic [FRACTION_WIDTH-1:0]       prod_frac;
    logic [DW-1:0]                   prod_digit;

    always_comb
    begin
        radix_sat = radix_reg;
        if (radix_reg < rnta_pkg::RADIX_MIN)
        begin
            radix_sat = rnta_pkg::RADIX_MIN;
        end
        else if (radix_reg > rnta_pkg::RADIX_MAX)
        begin
            radix_sat = rnta_pkg::RADIX_MAX;
        end
        fdig_sat = (fdig_reg > rnta_pkg::FDIG_MAX) ? rnta_pkg::FDIG_MAX : fdig_reg;
    end

    always_comb
    begin
        radix_next = radix_reg;
        fdig_next  = fdig_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rnta_pkg::REG_RADIX:           radix_next = cfg_data;
                rnta_pkg::REG_FRACTION_DIGITS: fdig_next  = cfg_data;
                default:                       radix_next = radix_reg;
            endcase
        end
    end

    // Restoring division by the radix, DIV_STEPS quotient bits per cycle
    always_comb
    begin
        div_d = div_reg;
        div_r = {1'b0, rem_reg};
        for (int i = 0; i < rnta_pkg::DIV_STEPS; i++)
        begin
            div_r = {div_r[RW-2:0], div_d[DIV_BITS-1]};
            div_d = {div_d[DIV_BITS-2:0], 1'b0};
            if (div_r >= radix_sat)
            begin
                div_r    = div_r - radix_sat;
                div_d[0] = 1'b1;
            end
        end
    end

    // One fraction digit: multiply, split off the integer part
    assign prod       = PROD_W'(frac_reg) * PROD_W'(radix_sat);
    assign prod_frac  = prod[FRACTION_WIDTH-1:0];
    assign prod_digit = prod[FRACTION_WIDTH+DW-1:FRACTION_WIDTH];

    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.quo_zero   = (div_d == '0);
    assign stat.pop_last   = (depth_reg == DEPTH_W'(1));
    assign stat.point_last = (frac_reg == '0) || (fd_left_reg == '0);
    assign stat.frac_last  = (prod_frac == '0) || (fd_left_reg == rnta_pkg::FDIG_WIDTH'(1));

    always_comb
    begin
        div_next     = div_reg;
        rem_next     = rem_reg;
        frac_next    = frac_reg;
        fd_left_next = fd_left_reg;
        sign_next    = sign_reg;
        depth_next   = depth_reg;
        stack_next   = stack_reg;
        if (cmd.load)
        begin
            div_next     = DIV_BITS'(whole_part[WHOLE_WIDTH-1:0]);
            rem_next     = '0;
            frac_next    = fraction_part[FRACTION_WIDTH-1:0];
            fd_left_next = fdig_sat;
            sign_next    = is_negative;
            depth_next   = '0;
        end
        if (cmd.div_step)
        begin
            div_next = div_d;
            rem_next = cmd.div_finish ? '0 : div_r[DW-1:0];
        end
        if (cmd.div_finish)
        begin
            // push the remainder digit onto the stack
            stack_next[0] = div_r[DW-1:0];
            for (int i = 1; i < WHOLE_WIDTH; i++)
            begin
                stack_next[i] = stack_reg[i-1];
            end
            depth_next = depth_reg + 1'b1;
        end
        if (cmd.emit_pop)
        begin
            for (int i = 0; i < WHOLE_WIDTH - 1; i++)
            begin
                stack_next[i] = stack_reg[i+1];
            end
            depth_next = depth_reg - 1'b1;
        end
        if (cmd.emit_frac)
        begin
            frac_next    = prod_frac;
            fd_left_next = fd_left_reg - 1'b1;
        end
    end

    always_comb
    begin
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit_sign)
        begin
            char_next = sign_reg ? rnta_pkg::CHAR_MINUS : rnta_pkg::CHAR_PLUS;
            last_next = 1'b0;
        end
        else if (cmd.emit_pop)
        begin
            char_next = rnta_pkg::digit_char(stack_reg[0]);
            last_next = 1'b0;
        end
        else if (cmd.emit_point)
        begin
            char_next = rnta_pkg::CHAR_POINT;
            last_next = stat.point_last;
        end
        else if (cmd.emit_frac)
        begin
            char_next = rnta_pkg::digit_char(prod_digit);
            last_next = stat.frac_last;
        end
        if (cmd.emit_sign || cmd.emit_pop || cmd.emit_point || cmd.emit_frac)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rnta_pkg::RADIX_RESET;
            fdig_reg      <= rnta_pkg::FDIG_RESET;
            out_valid_reg <= 1'b0;
            depth_reg     <= '0;
        end
        else
        begin
            radix_reg     <= radix_next;
            fdig_reg      <= fdig_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        frac_reg    <= frac_next;
        fd_left_reg <= fd_left_next;
        sign_reg    <= sign_next;
        stack_reg   <= stack_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

### design/radix_number_to_ascii.sv
// radix_number_to_ascii: top level of the fixed-point to base-N text converter.
// Depends on rnta_pkg, rnta_ctrl and rnta_dpath.
//
//   channel   direction  handshake               beat payload
//   -------   ---------  ----------------------  -----------------------------------------
//   in        input      in_valid / in_stall     is_negative, whole_part, fraction_part
//   out       output     out_valid / out_stall   character, last
//   cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One number at a time. After an input beat is taken, the radix divider produces
// each integer digit in turn (8 quotient bits per cycle); then the sign, the
// integer digits, the point and the fraction digits go out one character at a
// time, with one fraction multiply per digit.
// Reset restores radix 10 and 6 fraction digits and empties the output register.
// A stall on the output holds the character register and pauses the sequencer;
// in_stall stays high until the last character of a number is in the output
// register. Configuration beats are always taken (cfg_ready is tied high).
module radix_number_to_ascii #(
    parameter int WHOLE_WIDTH    = 31,
    parameter int FRACTION_WIDTH = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // number in
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     is_negative,
    input  logic [rnta_pkg::WHOLE_PORT_WIDTH-1:0]    whole_part,
    input  logic [rnta_pkg::FRACTION_PORT_WIDTH-1:0] fraction_part,
    // characters out
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [rnta_pkg::CHAR_WIDTH-1:0]          character,
    output logic                                     last,
    // register writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [rnta_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [rnta_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    rnta_pkg::cmd_t    cmd;
    rnta_pkg::status_t stat;

    // Registers accept a write in any cycle; software is to write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    // Sequencer: divide, then sign, digits, point, fraction digits
    rnta_ctrl #(
        .WHOLE_WIDTH (WHOLE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Divider, digit stack, fraction multiplier and output register
    rnta_dpath #(
        .WHOLE_WIDTH    (WHOLE_WIDTH),
        .FRACTION_WIDTH (FRACTION_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .is_negative   (is_negative),
        .whole_part    (whole_part),
        .fraction_part (fraction_part),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .character     (character),
        .last          (last)
    );

endmodule
